// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a consequence in the same cycle as its cause
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pow_pkg.sv =====
// Types, constants and helper functions of the parallel one-wire master
package pow_pkg;

   localparam int LANES       = 16;
   localparam int LANE_W      = $clog2(LANES);
   localparam int HALF_LANES  = LANES / 2;
   localparam int BYTE_W      = 8;
   localparam int BIT_W       = 3;
   localparam int US_W        = 10;
   localparam int SHORT_W     = 8;
   localparam int CFG_W       = 10;
   localparam int CFG_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_RESET_LOW   = 3'd0,
      CSR_RESET_WAIT  = 3'd1,
      CSR_WRITE_GAP   = 3'd2,
      CSR_WRITE_LOW   = 3'd3,
      CSR_SLOT        = 3'd4,
      CSR_READ_LOW    = 3'd5,
      CSR_READ_SAMPLE = 3'd6,
      CSR_READ_REST   = 3'd7
   } csr_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_LOW   = 4'd1,
      PH_RST_WAIT  = 4'd2,
      PH_WR_GAP    = 4'd3,
      PH_WR_LOW    = 4'd4,
      PH_WR_HOLD   = 4'd5,
      PH_RD_LOW    = 4'd6,
      PH_RD_SAMPLE = 4'd7,
      PH_RD_REST   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      MODE_RUN    = 2'd0,
      MODE_SETTLE = 2'd1,
      MODE_EMIT   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [US_W-1:0]    reset_low;
      logic [US_W-1:0]    reset_wait;
      logic [SHORT_W-1:0] write_gap;
      logic [SHORT_W-1:0] write_low;
      logic [SHORT_W-1:0] slot;
      logic [SHORT_W-1:0] read_low;
      logic [SHORT_W-1:0] read_sample;
      logic [SHORT_W-1:0] read_rest;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      reset_low:   US_W'(700),
      reset_wait:  US_W'(330),
      write_gap:   SHORT_W'(5),
      write_low:   SHORT_W'(2),
      slot:        SHORT_W'(60),
      read_low:    SHORT_W'(4),
      read_sample: SHORT_W'(8),
      read_rest:   SHORT_W'(50)
   };

   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  tx_byte;
      logic [BYTE_W-1:0]  pin_a;
      logic [BYTE_W-1:0]  pin_b;
   } cmd_type;

   typedef struct packed {
      logic               drive_low;
      logic               busy_res;
      logic               byte_valid;
      logic [LANE_W-1:0]  lane;
      logic [BYTE_W-1:0]  lane_byte;
      logic               last;
   } rsp_type;

   function automatic logic [US_W-1:0] phase_len(phase_type ph, cfg_type c);
      logic [US_W-1:0] len;
      case (ph)
         PH_RST_LOW:   len = c.reset_low;
         PH_RST_WAIT:  len = c.reset_wait;
         PH_WR_GAP:    len = US_W'(c.write_gap);
         PH_WR_LOW:    len = US_W'(c.write_low);
         PH_WR_HOLD:   len = US_W'(c.slot);
         PH_RD_LOW:    len = US_W'(c.read_low);
         PH_RD_SAMPLE: len = US_W'(c.read_sample);
         PH_RD_REST:   len = US_W'(c.read_rest);
         default:      len = US_W'(1);
      endcase
      return len;
   endfunction

   function automatic logic enter_drive(phase_type ph, logic [BYTE_W-1:0] tx,
                                        logic [BIT_W-1:0] bitn);
      logic drv;
      case (ph)
         PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drv = 1'b1;
         PH_WR_HOLD:                       drv = ~tx[bitn];
         default:                          drv = 1'b0;
      endcase
      return drv;
   endfunction

endpackage

// ===== hw/rtl/pow_req_if.sv =====
// Request channel: operation, byte to write and sensed pin levels
interface pow_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 operation;
   logic [pow_pkg::BYTE_W-1:0] tx_byte;
   logic [pow_pkg::BYTE_W-1:0] port_a_pins;
   logic [pow_pkg::BYTE_W-1:0] port_b_pins;

   modport source (output valid, operation, tx_byte, port_a_pins, port_b_pins,
                   input ready);
   modport sink   (input valid, operation, tx_byte, port_a_pins, port_b_pins,
                   output ready);
endinterface

// ===== hw/rtl/pow_rsp_if.sv =====
// Response channel: bus drive, busy flag and received lane bytes
interface pow_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       drive_low;
   logic                       busy_res;
   logic                       byte_valid;
   logic [pow_pkg::LANE_W-1:0] lane;
   logic [pow_pkg::BYTE_W-1:0] lane_byte;
   logic                       last;

   modport source (output valid, drive_low, busy_res, byte_valid, lane, lane_byte, last,
                   input ready);
   modport sink   (input valid, drive_low, busy_res, byte_valid, lane, lane_byte, last,
                   output ready);
endinterface

// ===== hw/rtl/pow_front.sv =====
// Front end: accept requests, decode the operation and queue them for the sequencer
`include "assert_macros.svh"

module pow_front (
   input  logic              clock,
   input  logic              reset,
   pow_req_if.sink           req,
   output logic              cmd_valid,
   output pow_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);

   logic [pow_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pow_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pow_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   pow_pkg::cmd_type                slot_ff [pow_pkg::QUEUE_DEPTH];
   pow_pkg::cmd_type                cmd_in;
   logic                            push;

   assign req.ready = count_ff != pow_pkg::QUEUE_CNT_W'(pow_pkg::QUEUE_DEPTH);
   assign push      = req.valid && req.ready;
   assign cmd_valid = count_ff != '0;
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      cmd_in.op      = pow_pkg::op_type'(req.operation);
      cmd_in.tx_byte = req.tx_byte;
      cmd_in.pin_a   = req.port_a_pins;
      cmd_in.pin_b   = req.port_b_pins;
      wr_ptr_in      = wr_ptr_ff + pow_pkg::QUEUE_PTR_W'(push);
      rd_ptr_in      = rd_ptr_ff + pow_pkg::QUEUE_PTR_W'(cmd_pop);
      count_in       = count_ff + pow_pkg::QUEUE_CNT_W'(push)
                                - pow_pkg::QUEUE_CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   `ASSERT_SAME(a_pop_nonempty, clock, reset, cmd_pop, count_ff != '0, "pop from empty queue")
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= pow_pkg::QUEUE_CNT_W'(pow_pkg::QUEUE_DEPTH), "queue overfilled")

endmodule

// ===== hw/rtl/pow_back.sv =====
// Back end: bus phase sequencer, settings registers and lane receive store
`include "assert_macros.svh"

module pow_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [pow_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [pow_pkg::CFG_W-1:0]         csr_wdata,
   input  logic                              cmd_valid,
   input  pow_pkg::cmd_type                  cmd,
   output logic                              cmd_pop,
   input  logic                              out_ready,
   output logic                              out_valid,
   output pow_pkg::rsp_type                  out_data
);

   pow_pkg::cfg_type                cfg_ff;
   pow_pkg::phase_type              phase_ff, phase_in;
   pow_pkg::mode_type               mode_ff, mode_in;
   logic [pow_pkg::US_W-1:0]        us_ff, us_in;
   logic [pow_pkg::BIT_W-1:0]       bit_ff, bit_in;
   logic [pow_pkg::BYTE_W-1:0]      tx_ff, tx_in;
   logic                            drive_ff, drive_in;
   logic [pow_pkg::LANE_W-1:0]      lane_ff, lane_in;
   logic [pow_pkg::BYTE_W-1:0]      pin_a_ff, pin_a_in;
   logic [pow_pkg::BYTE_W-1:0]      pin_b_ff, pin_b_in;
   logic [pow_pkg::BYTE_W-1:0]      rx_ff [pow_pkg::LANES];
   logic [pow_pkg::BYTE_W-1:0]      rx_in [pow_pkg::LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pow_pkg::CFG_RESET;
      end else if (csr_write_en) begin
         case (pow_pkg::csr_type'(csr_index))
            pow_pkg::CSR_RESET_LOW:   cfg_ff.reset_low   <= csr_wdata;
            pow_pkg::CSR_RESET_WAIT:  cfg_ff.reset_wait  <= csr_wdata;
            pow_pkg::CSR_WRITE_GAP:   cfg_ff.write_gap   <= csr_wdata[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_WRITE_LOW:   cfg_ff.write_low   <= csr_wdata[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_SLOT:        cfg_ff.slot        <= csr_wdata[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_READ_LOW:    cfg_ff.read_low    <= csr_wdata[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_READ_SAMPLE: cfg_ff.read_sample <= csr_wdata[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_READ_REST:   cfg_ff.read_rest   <= csr_wdata[pow_pkg::SHORT_W-1:0];
            default:                  cfg_ff             <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      logic [pow_pkg::US_W:0]     cnt;
      logic                       do_leave;
      logic                       step_done;
      logic                       emit;
      logic [pow_pkg::BYTE_W-1:0] pa;
      logic [pow_pkg::BYTE_W-1:0] pb;
      pow_pkg::phase_type         nxt;

      phase_in  = phase_ff;
      mode_in   = mode_ff;
      us_in     = us_ff;
      bit_in    = bit_ff;
      tx_in     = tx_ff;
      drive_in  = drive_ff;
      lane_in   = lane_ff;
      pin_a_in  = pin_a_ff;
      pin_b_in  = pin_b_ff;
      rx_in     = rx_ff;
      cmd_pop   = 1'b0;
      out_valid = 1'b0;
      out_data  = '0;
      cnt       = '0;
      do_leave  = 1'b0;
      step_done = 1'b0;
      emit      = 1'b0;
      nxt       = pow_pkg::PH_IDLE;
      pa        = (mode_ff == pow_pkg::MODE_RUN) ? cmd.pin_a : pin_a_ff;
      pb        = (mode_ff == pow_pkg::MODE_RUN) ? cmd.pin_b : pin_b_ff;

      case (mode_ff)
         pow_pkg::MODE_RUN: begin
            if (cmd_valid && out_ready) begin
               cmd_pop   = 1'b1;
               step_done = 1'b1;
               pin_a_in  = cmd.pin_a;
               pin_b_in  = cmd.pin_b;
               if (cmd.op == pow_pkg::OP_TICK) begin
                  if (phase_ff != pow_pkg::PH_IDLE) begin
                     cnt = {1'b0, us_ff} + (pow_pkg::US_W + 1)'(1);
                     if (cnt >= {1'b0, pow_pkg::phase_len(phase_ff, cfg_ff)}) begin
                        do_leave = 1'b1;
                     end else begin
                        us_in = cnt[pow_pkg::US_W-1:0];
                     end
                  end
               end else if (phase_ff == pow_pkg::PH_IDLE) begin
                  bit_in = '0;
                  us_in  = '0;
                  case (cmd.op)
                     pow_pkg::OP_RESET: phase_in = pow_pkg::PH_RST_LOW;
                     pow_pkg::OP_WRITE: begin
                        tx_in    = cmd.tx_byte;
                        phase_in = pow_pkg::PH_WR_GAP;
                     end
                     default: begin
                        for (int j = 0; j < pow_pkg::LANES; j++) begin
                           rx_in[j] = '0;
                        end
                        phase_in = pow_pkg::PH_RD_LOW;
                     end
                  endcase
                  drive_in = pow_pkg::enter_drive(phase_in, tx_in, bit_in);
               end
            end
         end
         pow_pkg::MODE_SETTLE: begin
            if (out_ready) begin
               do_leave  = 1'b1;
               step_done = 1'b1;
            end
         end
         pow_pkg::MODE_EMIT: begin
            if (out_ready) begin
               out_valid           = 1'b1;
               out_data.drive_low  = drive_ff;
               out_data.busy_res   = phase_ff != pow_pkg::PH_IDLE;
               out_data.byte_valid = 1'b1;
               out_data.lane       = lane_ff;
               out_data.lane_byte  = rx_ff[lane_ff];
               out_data.last       = lane_ff == pow_pkg::LANE_W'(pow_pkg::LANES - 1);
               lane_in             = lane_ff + pow_pkg::LANE_W'(1);
               if (out_data.last) begin
                  mode_in = pow_pkg::MODE_RUN;
               end
            end
         end
         default: mode_in = pow_pkg::MODE_RUN;
      endcase

      if (do_leave) begin
         case (phase_ff)
            pow_pkg::PH_RST_LOW:   nxt = pow_pkg::PH_RST_WAIT;
            pow_pkg::PH_WR_GAP:    nxt = pow_pkg::PH_WR_LOW;
            pow_pkg::PH_WR_LOW:    nxt = pow_pkg::PH_WR_HOLD;
            pow_pkg::PH_WR_HOLD: begin
               if (bit_ff == '1) begin
                  bit_in = '0;
                  nxt    = pow_pkg::PH_IDLE;
               end else begin
                  bit_in = bit_ff + pow_pkg::BIT_W'(1);
                  nxt    = pow_pkg::PH_WR_GAP;
               end
            end
            pow_pkg::PH_RD_LOW:    nxt = pow_pkg::PH_RD_SAMPLE;
            pow_pkg::PH_RD_SAMPLE: begin
               for (int j = 0; j < pow_pkg::HALF_LANES; j++) begin
                  rx_in[j] = rx_ff[j]
                     | (pow_pkg::BYTE_W'(pa[pow_pkg::HALF_LANES-1-j]) << bit_ff);
                  rx_in[j + pow_pkg::HALF_LANES] = rx_ff[j + pow_pkg::HALF_LANES]
                     | (pow_pkg::BYTE_W'(pb[j]) << bit_ff);
               end
               nxt = pow_pkg::PH_RD_REST;
            end
            pow_pkg::PH_RD_REST: begin
               if (bit_ff == '1) begin
                  bit_in = '0;
                  emit   = 1'b1;
                  nxt    = pow_pkg::PH_IDLE;
               end else begin
                  bit_in = bit_ff + pow_pkg::BIT_W'(1);
                  nxt    = pow_pkg::PH_RD_LOW;
               end
            end
            default: nxt = pow_pkg::PH_IDLE;
         endcase
         phase_in = nxt;
         us_in    = '0;
         drive_in = pow_pkg::enter_drive(nxt, tx_ff, bit_in);
      end

      if (step_done) begin
         if (phase_in != pow_pkg::PH_IDLE
             && pow_pkg::phase_len(phase_in, cfg_ff) == '0) begin
            mode_in = pow_pkg::MODE_SETTLE;
         end else if (emit) begin
            mode_in = pow_pkg::MODE_EMIT;
            lane_in = '0;
         end else begin
            mode_in            = pow_pkg::MODE_RUN;
            out_valid          = 1'b1;
            out_data.drive_low = drive_in;
            out_data.busy_res  = phase_in != pow_pkg::PH_IDLE;
            out_data.last      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pow_pkg::PH_IDLE;
         mode_ff  <= pow_pkg::MODE_RUN;
         us_ff    <= '0;
         bit_ff   <= '0;
         tx_ff    <= '0;
         drive_ff <= 1'b0;
         lane_ff  <= '0;
         for (int j = 0; j < pow_pkg::LANES; j++) begin
            rx_ff[j] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         us_ff    <= us_in;
         bit_ff   <= bit_in;
         tx_ff    <= tx_in;
         drive_ff <= drive_in;
         lane_ff  <= lane_in;
         rx_ff    <= rx_in;
      end
   end

   always_ff @(posedge clock) begin
      pin_a_ff <= pin_a_in;
      pin_b_ff <= pin_b_in;
   end

   `ASSERT_SAME(a_emit_idle, clock, reset, mode_ff == pow_pkg::MODE_EMIT, phase_ff == pow_pkg::PH_IDLE && !drive_ff, "lane burst outside idle")
   `ASSERT_SAME(a_settle_busy, clock, reset, mode_ff == pow_pkg::MODE_SETTLE, phase_ff != pow_pkg::PH_IDLE, "settling while idle")
   `ASSERT_NEXT(a_burst_end, clock, reset, mode_ff == pow_pkg::MODE_EMIT && out_ready && lane_ff == pow_pkg::LANE_W'(pow_pkg::LANES - 1), mode_ff == pow_pkg::MODE_RUN, "burst did not end after last lane")

endmodule

// ===== hw/rtl/pow_out.sv =====
// Output register stage between the sequencer and the response channel
module pow_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              out_valid,
   input  pow_pkg::rsp_type  out_data,
   output logic              out_ready,
   pow_rsp_if.source         rsp
);

   logic             valid_ff, valid_in;
   pow_pkg::rsp_type data_ff;

   assign out_ready = !valid_ff || rsp.ready;
   assign valid_in  = out_ready ? out_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && out_valid) begin
         data_ff <= out_data;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.drive_low  = data_ff.drive_low;
   assign rsp.busy_res   = data_ff.busy_res;
   assign rsp.byte_valid = data_ff.byte_valid;
   assign rsp.lane       = data_ff.lane;
   assign rsp.lane_byte  = data_ff.lane_byte;
   assign rsp.last       = data_ff.last;

endmodule

// ===== hw/rtl/parallel_one_wire_master_core.sv =====
// A request passes the front-end queue, the sequencer and the output register.
// Throughput: one request per cycle while responses are taken; each zero-length
// phase crossed adds a settle step. A request that ends a read holds the sequencer
// for a step with no response, then sixteen lane responses, one per cycle while taken.
// Synchronous active-high reset: idle bus, default timings, receive store cleared.
// Top level of the sixteen-lane one-wire bus master
module parallel_one_wire_master_core (
   input  logic                          clock,
   input  logic                          reset,
   pow_req_if.sink                       req,
   pow_rsp_if.source                     rsp,
   input  logic                          csr_write_en,
   input  logic [pow_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [pow_pkg::CFG_W-1:0]     csr_wdata
);

   logic             cmd_valid;
   pow_pkg::cmd_type cmd;
   logic             cmd_pop;
   logic             out_valid;
   logic             out_ready;
   pow_pkg::rsp_type out_data;

   pow_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   pow_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .out_ready    (out_ready),
      .out_valid    (out_valid),
      .out_data     (out_data)
   );

   pow_out u_out (
      .clock     (clock),
      .reset     (reset),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_ready (out_ready),
      .rsp       (rsp)
   );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Testbench of the sixteen-lane one-wire master: timed bus commands checked against a predictor
module testbench;

   class lane_tracker;
      pow_pkg::cfg_type           timing;
      pow_pkg::phase_type         phase;
      logic [pow_pkg::US_W-1:0]   elapsed;
      logic [pow_pkg::BIT_W-1:0]  bit_pos;
      logic [pow_pkg::BYTE_W-1:0] tx_bits;
      logic [pow_pkg::BYTE_W-1:0] rx_lane [pow_pkg::LANES];
      logic                       pull_low;
      bit                         burst;
      logic [pow_pkg::BYTE_W-1:0] pins_a;
      logic [pow_pkg::BYTE_W-1:0] pins_b;
      pow_pkg::rsp_type           due_rsp [$];
      int                         mismatches;

      function new();
         timing = '{reset_low: pow_pkg::US_W'(700), reset_wait: pow_pkg::US_W'(330),
                    write_gap: pow_pkg::SHORT_W'(5), write_low: pow_pkg::SHORT_W'(2),
                    slot: pow_pkg::SHORT_W'(60), read_low: pow_pkg::SHORT_W'(4),
                    read_sample: pow_pkg::SHORT_W'(8), read_rest: pow_pkg::SHORT_W'(50)};
         phase = pow_pkg::PH_IDLE;
         elapsed = '0;
         bit_pos = '0;
         tx_bits = '0;
         foreach (rx_lane[i]) rx_lane[i] = '0;
         pull_low = 1'b0;
         burst = 1'b0;
         pins_a = '0;
         pins_b = '0;
         mismatches = 0;
      endfunction

      function logic [pow_pkg::US_W-1:0] duration(pow_pkg::phase_type p);
         case (p)
            pow_pkg::PH_RST_LOW:   return timing.reset_low;
            pow_pkg::PH_RST_WAIT:  return timing.reset_wait;
            pow_pkg::PH_WR_GAP:    return pow_pkg::US_W'(timing.write_gap);
            pow_pkg::PH_WR_LOW:    return pow_pkg::US_W'(timing.write_low);
            pow_pkg::PH_WR_HOLD:   return pow_pkg::US_W'(timing.slot);
            pow_pkg::PH_RD_LOW:    return pow_pkg::US_W'(timing.read_low);
            pow_pkg::PH_RD_SAMPLE: return pow_pkg::US_W'(timing.read_sample);
            pow_pkg::PH_RD_REST:   return pow_pkg::US_W'(timing.read_rest);
            default:               return pow_pkg::US_W'(1);
         endcase
      endfunction

      function void enter_phase(pow_pkg::phase_type p);
         phase = p;
         elapsed = '0;
         case (p)
            pow_pkg::PH_RST_LOW, pow_pkg::PH_WR_LOW, pow_pkg::PH_RD_LOW: pull_low = 1'b1;
            pow_pkg::PH_WR_HOLD: pull_low = ~tx_bits[bit_pos];
            default:             pull_low = 1'b0;
         endcase
      endfunction

      function void capture_lanes();
         for (int j = 0; j < pow_pkg::HALF_LANES; j++) begin
            rx_lane[j][bit_pos] = rx_lane[j][bit_pos] | pins_a[7 - j];
            rx_lane[j + pow_pkg::HALF_LANES][bit_pos] =
               rx_lane[j + pow_pkg::HALF_LANES][bit_pos] | pins_b[j];
         end
      endfunction

      function void next_slot(pow_pkg::phase_type first);
         if (bit_pos == 3'd7) begin
            bit_pos = '0;
            if (first == pow_pkg::PH_RD_LOW) burst = 1'b1;
            enter_phase(pow_pkg::PH_IDLE);
         end else begin
            bit_pos = bit_pos + 1'b1;
            enter_phase(first);
         end
      endfunction

      function void end_phase();
         case (phase)
            pow_pkg::PH_RST_LOW:   enter_phase(pow_pkg::PH_RST_WAIT);
            pow_pkg::PH_RST_WAIT:  enter_phase(pow_pkg::PH_IDLE);
            pow_pkg::PH_WR_GAP:    enter_phase(pow_pkg::PH_WR_LOW);
            pow_pkg::PH_WR_LOW:    enter_phase(pow_pkg::PH_WR_HOLD);
            pow_pkg::PH_WR_HOLD:   next_slot(pow_pkg::PH_WR_GAP);
            pow_pkg::PH_RD_LOW:    enter_phase(pow_pkg::PH_RD_SAMPLE);
            pow_pkg::PH_RD_SAMPLE: begin
               capture_lanes();
               enter_phase(pow_pkg::PH_RD_REST);
            end
            pow_pkg::PH_RD_REST:   next_slot(pow_pkg::PH_RD_LOW);
            default:               enter_phase(pow_pkg::PH_IDLE);
         endcase
      endfunction

      function void skip_empty();
         while (phase != pow_pkg::PH_IDLE && duration(phase) == '0) end_phase();
      endfunction

      function bit busy();
         return phase != pow_pkg::PH_IDLE;
      endfunction

      function int waiting();
         return due_rsp.size();
      endfunction

      function void set_timing(pow_pkg::csr_type idx, logic [pow_pkg::CFG_W-1:0] value);
         case (idx)
            pow_pkg::CSR_RESET_LOW:   timing.reset_low = value;
            pow_pkg::CSR_RESET_WAIT:  timing.reset_wait = value;
            pow_pkg::CSR_WRITE_GAP:   timing.write_gap = value[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_WRITE_LOW:   timing.write_low = value[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_SLOT:        timing.slot = value[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_READ_LOW:    timing.read_low = value[pow_pkg::SHORT_W-1:0];
            pow_pkg::CSR_READ_SAMPLE: timing.read_sample = value[pow_pkg::SHORT_W-1:0];
            default:                  timing.read_rest = value[pow_pkg::SHORT_W-1:0];
         endcase
      endfunction

      function void take_command(pow_pkg::cmd_type c);
         pow_pkg::rsp_type r;
         pins_a = c.pin_a;
         pins_b = c.pin_b;
         burst = 1'b0;
         if (c.op == pow_pkg::OP_TICK) begin
            if (phase != pow_pkg::PH_IDLE) begin
               elapsed = elapsed + 1'b1;
               if (elapsed >= duration(phase)) end_phase();
               skip_empty();
            end
         end else if (phase == pow_pkg::PH_IDLE) begin
            bit_pos = '0;
            case (c.op)
               pow_pkg::OP_RESET: enter_phase(pow_pkg::PH_RST_LOW);
               pow_pkg::OP_WRITE: begin
                  tx_bits = c.tx_byte;
                  enter_phase(pow_pkg::PH_WR_GAP);
               end
               default: begin
                  foreach (rx_lane[i]) rx_lane[i] = '0;
                  enter_phase(pow_pkg::PH_RD_LOW);
               end
            endcase
            skip_empty();
         end
         r.drive_low = pull_low;
         r.busy_res = busy();
         if (burst) begin
            for (int k = 0; k < pow_pkg::LANES; k++) begin
               r.byte_valid = 1'b1;
               r.lane = pow_pkg::LANE_W'(k);
               r.lane_byte = rx_lane[k];
               r.last = (k == pow_pkg::LANES - 1);
               due_rsp.push_back(r);
            end
         end else begin
            r.byte_valid = 1'b0;
            r.lane = '0;
            r.lane_byte = '0;
            r.last = 1'b1;
            due_rsp.push_back(r);
         end
      endfunction

      task report(string what);
         $display("mismatch at %0t ns: %s", $time, what);
         mismatches++;
      endtask

      task check_response(pow_pkg::rsp_type got);
         pow_pkg::rsp_type want;
         if (due_rsp.size() == 0) begin
            report($sformatf("response %h with nothing due", got));
         end else begin
            want = due_rsp.pop_front();
            if (got.drive_low !== want.drive_low)
               report($sformatf("drive_low %b, due %b", got.drive_low, want.drive_low));
            if (got.busy_res !== want.busy_res)
               report($sformatf("busy_res %b, due %b", got.busy_res, want.busy_res));
            if (got.byte_valid !== want.byte_valid)
               report($sformatf("byte_valid %b, due %b", got.byte_valid, want.byte_valid));
            if (got.lane !== want.lane)
               report($sformatf("lane %0d, due %0d", got.lane, want.lane));
            if (got.lane_byte !== want.lane_byte)
               report($sformatf("lane %0d byte %h, due %h", want.lane, got.lane_byte,
                                want.lane_byte));
            if (got.last !== want.last)
               report($sformatf("last %b, due %b", got.last, want.last));
         end
      endtask

      task check_drained();
         if (due_rsp.size() != 0)
            report($sformatf("%0d responses never came", due_rsp.size()));
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_en;
   logic [pow_pkg::CFG_IDX_W-1:0] csr_index;
   logic [pow_pkg::CFG_W-1:0]     csr_wdata;

   pow_req_if req ();
   pow_rsp_if rsp ();

   lane_tracker tracker;
   bit          steady;
   int          useful_items;

   parallel_one_wire_master_core dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 75) return 0;
      if (roll < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic pow_pkg::op_type pick_start();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) return pow_pkg::OP_RESET;
      if (roll < 6) return pow_pkg::OP_WRITE;
      return pow_pkg::OP_READ;
   endfunction

   function automatic logic [pow_pkg::CFG_W-1:0] pad(logic [pow_pkg::SHORT_W-1:0] v);
      return {(pow_pkg::CFG_W - pow_pkg::SHORT_W)'($urandom), v};
   endfunction

   function automatic pow_pkg::cfg_type small_timing();
      pow_pkg::cfg_type t;
      t.reset_low   = pow_pkg::US_W'($urandom_range(1, 4));
      t.reset_wait  = pow_pkg::US_W'($urandom_range(1, 4));
      t.write_gap   = pow_pkg::SHORT_W'($urandom_range(0, 2));
      t.write_low   = pow_pkg::SHORT_W'($urandom_range(1, 2));
      t.slot        = pow_pkg::SHORT_W'($urandom_range(1, 3));
      t.read_low    = pow_pkg::SHORT_W'($urandom_range(1, 2));
      t.read_sample = pow_pkg::SHORT_W'($urandom_range(1, 2));
      t.read_rest   = pow_pkg::SHORT_W'($urandom_range(0, 2));
      return t;
   endfunction

   initial begin : rsp_pacing
      int stall;
      stall = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            stall--;
         end else begin
            rsp.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : rsp_watch
      pow_pkg::rsp_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.drive_low  = rsp.drive_low;
         got.busy_res   = rsp.busy_res;
         got.byte_valid = rsp.byte_valid;
         got.lane       = rsp.lane;
         got.lane_byte  = rsp.lane_byte;
         got.last       = rsp.last;
         tracker.check_response(got);
      end
   end

   task automatic send(pow_pkg::op_type op, logic [pow_pkg::BYTE_W-1:0] tx,
                       logic [pow_pkg::BYTE_W-1:0] a, logic [pow_pkg::BYTE_W-1:0] b);
      int               gap;
      pow_pkg::cmd_type c;
      gap = pick_gap();
      c.op = op;
      c.tx_byte = tx;
      c.pin_a = a;
      c.pin_b = b;
      if (gap > 0) begin
         @(negedge clock);
         req.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid       <= 1'b1;
      req.operation   <= op;
      req.tx_byte     <= tx;
      req.port_a_pins <= a;
      req.port_b_pins <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      tracker.take_command(c);
   endtask

   task automatic tick();
      send(pow_pkg::OP_TICK, pow_pkg::BYTE_W'($urandom), pow_pkg::BYTE_W'($urandom),
           pow_pkg::BYTE_W'($urandom));
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req.valid <= 1'b0;
      while (tracker.waiting() > 0) @(posedge clock);
   endtask

   task automatic tick_until_idle(int noise_pct);
      while (tracker.busy()) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send(pick_start(), pow_pkg::BYTE_W'($urandom), pow_pkg::BYTE_W'($urandom),
                 pow_pkg::BYTE_W'($urandom));
         end else begin
            tick();
            useful_items++;
         end
         if ($urandom_range(0, 299) == 0) hold_until_drained();
      end
   endtask

   task automatic start_and_finish(pow_pkg::op_type op, int noise_pct);
      send(op, pow_pkg::BYTE_W'($urandom), pow_pkg::BYTE_W'($urandom),
           pow_pkg::BYTE_W'($urandom));
      useful_items++;
      tick_until_idle(noise_pct);
   endtask

   task automatic write_csr(pow_pkg::csr_type idx, logic [pow_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      tracker.set_timing(idx, value);
   endtask

   task automatic program_timing(pow_pkg::cfg_type t);
      hold_until_drained();
      repeat (8) @(posedge clock);
      write_csr(pow_pkg::CSR_RESET_LOW, t.reset_low);
      write_csr(pow_pkg::CSR_RESET_WAIT, t.reset_wait);
      write_csr(pow_pkg::CSR_WRITE_GAP, pad(t.write_gap));
      write_csr(pow_pkg::CSR_WRITE_LOW, pad(t.write_low));
      write_csr(pow_pkg::CSR_SLOT, pad(t.slot));
      write_csr(pow_pkg::CSR_READ_LOW, pad(t.read_low));
      write_csr(pow_pkg::CSR_READ_SAMPLE, pad(t.read_sample));
      write_csr(pow_pkg::CSR_READ_REST, pad(t.read_rest));
   endtask

   initial begin : stimulus
      pow_pkg::cfg_type t;
      tracker = new();
      steady = 1'b1;
      useful_items = 0;
      req.valid = 1'b0;
      req.operation = pow_pkg::OP_TICK;
      req.tx_byte = '0;
      req.port_a_pins = '0;
      req.port_b_pins = '0;
      csr_write_en = 1'b0;
      csr_index = pow_pkg::CSR_RESET_LOW;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // start a read on the timings out of reset, then shorten them mid-read
      send(pow_pkg::OP_READ, 8'h00, 8'hA5, 8'h3C);
      repeat (30) tick();
      send(pow_pkg::OP_WRITE, 8'h55, 8'h00, 8'h00);

      t = '{reset_low: pow_pkg::US_W'(1), reset_wait: pow_pkg::US_W'(1),
            write_gap: pow_pkg::SHORT_W'(0), write_low: pow_pkg::SHORT_W'(1),
            slot: pow_pkg::SHORT_W'(1), read_low: pow_pkg::SHORT_W'(1),
            read_sample: pow_pkg::SHORT_W'(1), read_rest: pow_pkg::SHORT_W'(0)};
      program_timing(t);
      steady = 1'b0;
      tick_until_idle(0);
      send(pow_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF);
      send(pow_pkg::OP_RESET, 8'h00, 8'h00, 8'h00);
      send(pow_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF);
      tick_until_idle(0);
      send(pow_pkg::OP_WRITE, 8'hFF, 8'h00, 8'h00);
      tick_until_idle(0);
      send(pow_pkg::OP_READ, 8'h00, 8'hFF, 8'h00);
      for (int k = 0; tracker.busy(); k++)
         send(pow_pkg::OP_TICK, 8'h00, 8'h01 << (k % 8), 8'h80 >> (k % 8));

      // widest timings, cut short once the counters are running
      t = '{reset_low: pow_pkg::US_W'(1023), reset_wait: pow_pkg::US_W'(1023),
            write_gap: pow_pkg::SHORT_W'(255), write_low: pow_pkg::SHORT_W'(255),
            slot: pow_pkg::SHORT_W'(255), read_low: pow_pkg::SHORT_W'(255),
            read_sample: pow_pkg::SHORT_W'(255), read_rest: pow_pkg::SHORT_W'(255)};
      program_timing(t);
      steady = 1'b1;
      send(pow_pkg::OP_RESET, 8'h00, 8'h00, 8'h00);
      repeat (12) tick();
      program_timing(small_timing());
      tick_until_idle(0);

      useful_items = 0;
      while (useful_items < 130) begin
         program_timing(small_timing());
         steady = ($urandom_range(0, 3) == 0);
         repeat (2) begin
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) tick();
            start_and_finish(pick_start(), 5);
            if ($urandom_range(0, 7) == 0) hold_until_drained();
         end
      end

      @(negedge clock);
      req.valid <= 1'b0;
      for (int n = 0; n < 50000 && tracker.waiting() > 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      tracker.check_drained();
      if (tracker.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
